/* rtl/core/axis_angle_vector_rotate_core_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef AXIS_ANGLE_VECTOR_ROTATE_CORE_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_CORE_DEFINES_SVH

// Checked only while the block is out of reset.
`define AAVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define AAVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/aavr_pkg.sv */
package aavr_pkg;

  localparam int COORD_WIDTH = 32;

  // Depth of the axis normalization pipeline; the angle path is padded to it.
  localparam int NORM_LAT = 68;
  // Matrix build, row products, row sums and the output register.
  localparam int MATRIX_LAT = 6;

  localparam longint ONE_Q30 = 1073741824;
  localparam longint HALF_Q30 = 536870912;
  localparam longint CORDIC_GAIN = 652032874;
  localparam longint DEG_FULL = 360 * 65536;
  localparam longint DEG_QUARTER = 90 * 65536;

  localparam int CORDIC_STEPS = 22;
  localparam int ATAN_DEG_Q16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_ZERO_AXIS = 1'b1;

  typedef logic signed [31:0] unit_t;
  typedef logic signed [32:0] trig_t;
  typedef logic signed [33:0] q30_t;

  // Q2.30 product, rounded half up.
  function automatic logic signed [35:0] mulq(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    p = a * b;
    p = p + 68'(HALF_Q30);
    mulq = 36'(p >>> 30);
  endfunction

endpackage

/* rtl/core/aavr_if.sv */
interface aavr_item_if #(parameter int COORD_WIDTH = aavr_pkg::COORD_WIDTH);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] vec_x;
  logic signed [COORD_WIDTH-1:0] vec_y;
  logic signed [COORD_WIDTH-1:0] vec_z;
  logic signed [COORD_WIDTH-1:0] axis_x;
  logic signed [COORD_WIDTH-1:0] axis_y;
  logic signed [COORD_WIDTH-1:0] axis_z;
  logic signed [COORD_WIDTH-1:0] angle_deg;

  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
                output ready);
endinterface

interface aavr_result_if #(parameter int COORD_WIDTH = aavr_pkg::COORD_WIDTH);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] rot_x;
  logic signed [COORD_WIDTH-1:0] rot_y;
  logic signed [COORD_WIDTH-1:0] rot_z;
  logic status;

  modport source (output valid, rot_x, rot_y, rot_z, status, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, status, output ready);
endinterface

/* rtl/core/aavr_axis_norm.sv */
module aavr_axis_norm #(
  parameter int COORD_WIDTH = aavr_pkg::COORD_WIDTH
) (
  input  logic clk,
  input  logic en,
  input  logic signed [COORD_WIDTH-1:0] axis [3],
  output aavr_pkg::unit_t nrm [3]
);

  localparam int W = COORD_WIDTH;
  localparam int LW = $clog2(W + 1);
  localparam int SQ_STEPS = 32;
  localparam int DIV_STEPS = 31;

  typedef struct packed {
    logic [2:0][W-1:0] mag;
    logic [2:0] neg;
    logic [LW-1:0] len;
  } mag_t;

  typedef struct packed {
    logic [2:0][29:0] um;
    logic [2:0] neg;
  } scl_t;

  typedef struct packed {
    logic [2:0][59:0] sq;
    logic [2:0][29:0] um;
    logic [2:0] neg;
  } sq_t;

  typedef struct packed {
    logic [61:0] v;
    logic [62:0] res;
    logic [2:0][29:0] um;
    logic [2:0] neg;
  } sqrt_t;

  typedef struct packed {
    logic [30:0] den;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] quo;
    logic [2:0] neg;
  } div_t;

  logic [2:0][W-1:0] mag_c;
  logic [W-1:0] any_c;
  logic [LW-1:0] len_c;
  logic [2:0][W+29:0] wide_c;
  mag_t sa;
  scl_t sb;
  sq_t sc;
  sqrt_t sq_head;
  sqrt_t sq_st [1:SQ_STEPS];
  div_t dv_head;
  div_t dv_st [1:DIV_STEPS];

  // The OR of the magnitudes has the bit length of the largest one.
  always_comb begin
    any_c = '0;
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = axis[k][W-1] ? W'(-axis[k]) : W'(axis[k]);
      any_c = any_c | mag_c[k];
    end
    len_c = '0;
    for (int i = 0; i < W; i++) begin
      if (any_c[i]) len_c = LW'(i + 1);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wide_c[k] = (W + 30)'(sa.mag[k]);
      if (int'(sa.len) > 30) wide_c[k] = wide_c[k] >> (sa.len - LW'(30));
      else wide_c[k] = wide_c[k] << (LW'(30) - sa.len);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa.mag <= mag_c;
      sa.len <= len_c;
      for (int k = 0; k < 3; k++) sa.neg[k] <= axis[k][W-1];
      for (int k = 0; k < 3; k++) sb.um[k] <= wide_c[k][29:0];
      sb.neg <= sa.neg;
      for (int k = 0; k < 3; k++) sc.sq[k] <= 60'(sb.um[k]) * 60'(sb.um[k]);
      sc.um <= sb.um;
      sc.neg <= sb.neg;
      sq_head.v <= 62'(sc.sq[0]) + 62'(sc.sq[1]) + 62'(sc.sq[2]);
      sq_head.res <= '0;
      sq_head.um <= sc.um;
      sq_head.neg <= sc.neg;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * i);
    sqrt_t cur;
    sqrt_t nxt;
    logic [62:0] trial;

    if (i == 0) begin : g_first
      assign cur = sq_head;
    end else begin : g_next
      assign cur = sq_st[i];
    end

    always_comb begin
      nxt = cur;
      trial = cur.res + BIT;
      if ({1'b0, cur.v} >= trial) begin
        nxt.v = 62'({1'b0, cur.v} - trial);
        nxt.res = (cur.res >> 1) + BIT;
      end else begin
        nxt.res = cur.res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) sq_st[i+1] <= nxt;
    end
  end

  always_comb begin
    dv_head.den = sq_st[SQ_STEPS].res[30:0];
    dv_head.neg = sq_st[SQ_STEPS].neg;
    for (int k = 0; k < 3; k++) begin
      dv_head.rem[k] = 32'(sq_st[SQ_STEPS].um[k]);
      dv_head.quo[k] = '0;
    end
  end

  // Three restoring dividers share the norm; the first step takes the
  // magnitude as it is, later steps shift in zeros.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    div_t cur;
    div_t nxt;
    logic [2:0][31:0] t;
    logic [2:0] qb;

    if (i == 0) begin : g_first
      assign cur = dv_head;
    end else begin : g_next
      assign cur = dv_st[i];
    end

    always_comb begin
      nxt = cur;
      for (int k = 0; k < 3; k++) begin
        t[k] = (i == 0) ? cur.rem[k] : {cur.rem[k][30:0], 1'b0};
        qb[k] = t[k] >= {1'b0, cur.den};
        if (qb[k]) t[k] = t[k] - {1'b0, cur.den};
        nxt.rem[k] = t[k];
        nxt.quo[k] = {cur.quo[k][29:0], qb[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) dv_st[i+1] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nrm[k] <= dv_st[DIV_STEPS].neg[k] ? -32'(dv_st[DIV_STEPS].quo[k])
                                         : 32'(dv_st[DIV_STEPS].quo[k]);
      end
    end
  end

endmodule

/* rtl/core/aavr_sincos.sv */
module aavr_sincos #(
  parameter int COORD_WIDTH = aavr_pkg::COORD_WIDTH
) (
  input  logic clk,
  input  logic en,
  input  logic signed [COORD_WIDTH-1:0] ang,
  output aavr_pkg::trig_t cos_q,
  output aavr_pkg::trig_t sin_q
);

  localparam int W = COORD_WIDTH;
  localparam longint unsigned HALF_RANGE = 64'd1 << (W - 1);
  localparam longint unsigned DF = aavr_pkg::DEG_FULL;
  localparam longint unsigned DQ = aavr_pkg::DEG_QUARTER;
  // Offset by a multiple of a full turn so the angle becomes nonnegative.
  localparam longint unsigned OFF = ((HALF_RANGE + DF - 1) / DF) * DF;
  localparam int UW = $clog2(OFF + HALF_RANGE);
  localparam int NQ = UW - 24;
  localparam int SC_LAT = NQ + 4 + aavr_pkg::CORDIC_STEPS;
  localparam int PAD = aavr_pkg::NORM_LAT - SC_LAT;
  localparam int NS = aavr_pkg::CORDIC_STEPS;

  localparam logic [1:0] QUAD_I = 2'd0;
  localparam logic [1:0] QUAD_II = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV = 2'd3;

  typedef struct packed {
    aavr_pkg::trig_t x;
    aavr_pkg::trig_t y;
    logic signed [25:0] z;
    logic [1:0] q;
  } cord_t;

  typedef struct packed {
    aavr_pkg::trig_t c;
    aavr_pkg::trig_t s;
  } cs_t;

  logic [UW-1:0] u_head;
  logic [UW-1:0] md_st [1:NQ];
  logic q_hi;
  logic [24:0] r_hi;
  logic [1:0] q_lo;
  logic [22:0] r_lo;
  cord_t cd_head;
  cord_t cd_st [1:NS];
  cs_t cs_map;
  cs_t cs_c;

  always_ff @(posedge clk) begin
    if (en) u_head <= UW'(ang) + UW'(OFF);
  end

  // Reduction modulo a full turn, one quotient bit per stage.
  for (genvar j = 0; j < NQ; j++) begin : g_mod
    localparam logic [UW-1:0] SUB = UW'(DF << (NQ - 1 - j));
    logic [UW-1:0] cur;

    if (j == 0) begin : g_first
      assign cur = u_head;
    end else begin : g_next
      assign cur = md_st[j];
    end

    always_ff @(posedge clk) begin
      if (en) md_st[j+1] <= (cur >= SUB) ? cur - SUB : cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_hi <= md_st[NQ][24:0] >= 25'(2 * DQ);
      r_hi <= (md_st[NQ][24:0] >= 25'(2 * DQ)) ? md_st[NQ][24:0] - 25'(2 * DQ)
                                              : md_st[NQ][24:0];
      q_lo <= {q_hi, r_hi >= 25'(DQ)};
      r_lo <= (r_hi >= 25'(DQ)) ? 23'(r_hi - 25'(DQ)) : 23'(r_hi);
    end
  end

  always_comb begin
    cd_head.x = 33'(aavr_pkg::CORDIC_GAIN);
    cd_head.y = '0;
    cd_head.z = {3'b000, r_lo};
    cd_head.q = q_lo;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam logic signed [25:0] ATAN = 26'(aavr_pkg::ATAN_DEG_Q16[i]);
    cord_t cur;
    cord_t nxt;

    if (i == 0) begin : g_first
      assign cur = cd_head;
    end else begin : g_next
      assign cur = cd_st[i];
    end

    always_comb begin
      nxt = cur;
      if (!cur.z[25]) begin
        nxt.x = cur.x - (cur.y >>> i);
        nxt.y = cur.y + (cur.x >>> i);
        nxt.z = cur.z - ATAN;
      end else begin
        nxt.x = cur.x + (cur.y >>> i);
        nxt.y = cur.y - (cur.x >>> i);
        nxt.z = cur.z + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (en) cd_st[i+1] <= nxt;
    end
  end

  always_comb begin
    unique case (cd_st[NS].q)
      QUAD_I: begin
        cs_c.c = cd_st[NS].x;
        cs_c.s = cd_st[NS].y;
      end
      QUAD_II: begin
        cs_c.c = -cd_st[NS].y;
        cs_c.s = cd_st[NS].x;
      end
      QUAD_III: begin
        cs_c.c = -cd_st[NS].x;
        cs_c.s = -cd_st[NS].y;
      end
      QUAD_IV: begin
        cs_c.c = cd_st[NS].y;
        cs_c.s = -cd_st[NS].x;
      end
      default: begin
        cs_c.c = cd_st[NS].x;
        cs_c.s = cd_st[NS].y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) cs_map <= cs_c;
  end

  // Delay to line up with the axis normalization.
  if (PAD > 0) begin : g_pad
    cs_t pd [1:PAD];
    always_ff @(posedge clk) begin
      if (en) begin
        pd[1] <= cs_map;
        for (int k = 2; k <= PAD; k++) pd[k] <= pd[k-1];
      end
    end
    assign cos_q = pd[PAD].c;
    assign sin_q = pd[PAD].s;
  end else begin : g_nopad
    assign cos_q = cs_map.c;
    assign sin_q = cs_map.s;
  end

endmodule

/* rtl/core/axis_angle_vector_rotate_core.sv */
// Path from an accepted word to its result: the axis normalization, then the matrix stages.
// Throughput: one word per clock; a held result stalls the whole pipeline in place.
// The depth is set by the 32-step square root and 31-step divider of the axis norm.
// Reset clears the valid bits of all stages; data registers are not reset.
module axis_angle_vector_rotate_core #(
  parameter int COORD_WIDTH = aavr_pkg::COORD_WIDTH
) (
  input logic clk,
  input logic rst,
  aavr_item_if.sink item,
  aavr_result_if.source result
);

  localparam int W = COORD_WIDTH;
  localparam int NL = aavr_pkg::NORM_LAT;
  localparam int TOT = NL + aavr_pkg::MATRIX_LAT;
  localparam int SL = NL + 5;
  localparam int HW = (W > 24) ? W - 24 : 1;
  localparam int PHW = HW + 34;
  localparam int SW = HW + 62;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};

  typedef struct packed {
    logic [2:0][W-1:0] vec;
    logic zang;
    logic zax;
  } side_t;

  logic adv;
  logic [TOT:1] vld;
  side_t sd [1:SL];
  logic signed [W-1:0] axis_in [3];
  aavr_pkg::unit_t nrm [3];
  aavr_pkg::trig_t cos_q;
  aavr_pkg::trig_t sin_q;

  aavr_pkg::q30_t pp [6];
  aavr_pkg::q30_t qs1 [3];
  aavr_pkg::q30_t cc1;
  aavr_pkg::q30_t c1;
  aavr_pkg::q30_t tt [6];
  aavr_pkg::q30_t qs2 [3];
  aavr_pkg::q30_t c2;
  aavr_pkg::q30_t mm [9];
  logic signed [PHW-1:0] ph [3][3];
  logic signed [58:0] pl [3][3];
  logic signed [PHW+1:0] hs [3];
  logic signed [60:0] ls [3];
  logic signed [W+23:0] vx [3];
  logic signed [SW-1:0] tot [3];
  logic signed [SW-31:0] yv [3];
  logic signed [W-1:0] sat_c [3];
  logic signed [W-1:0] rot [3];
  logic status;

  assign adv = !vld[TOT] || result.ready;
  assign item.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-1:1], item.valid};
    end
  end

  // Vector and special-case flags ride alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (adv) begin
      sd[1].vec <= {item.vec_z, item.vec_y, item.vec_x};
      sd[1].zang <= item.angle_deg == '0;
      sd[1].zax <= (item.axis_x == '0) && (item.axis_y == '0) && (item.axis_z == '0);
      for (int k = 2; k <= SL; k++) sd[k] <= sd[k-1];
    end
  end

  assign axis_in[0] = item.axis_x;
  assign axis_in[1] = item.axis_y;
  assign axis_in[2] = item.axis_z;

  aavr_axis_norm #(.COORD_WIDTH(W)) u_norm (
    .clk (clk),
    .en  (adv),
    .axis(axis_in),
    .nrm (nrm)
  );

  aavr_sincos #(.COORD_WIDTH(W)) u_sincos (
    .clk  (clk),
    .en   (adv),
    .ang  (item.angle_deg),
    .cos_q(cos_q),
    .sin_q(sin_q)
  );

  // Matrix: products of the unit axis, then scale by 1 - c, then assemble.
  // Product order: xx, xy, xz, yy, yz, zz.
  always_ff @(posedge clk) begin
    if (adv) begin
      pp[0] <= 34'(aavr_pkg::mulq(34'(nrm[0]), 34'(nrm[0])));
      pp[1] <= 34'(aavr_pkg::mulq(34'(nrm[0]), 34'(nrm[1])));
      pp[2] <= 34'(aavr_pkg::mulq(34'(nrm[0]), 34'(nrm[2])));
      pp[3] <= 34'(aavr_pkg::mulq(34'(nrm[1]), 34'(nrm[1])));
      pp[4] <= 34'(aavr_pkg::mulq(34'(nrm[1]), 34'(nrm[2])));
      pp[5] <= 34'(aavr_pkg::mulq(34'(nrm[2]), 34'(nrm[2])));
      for (int k = 0; k < 3; k++) qs1[k] <= 34'(aavr_pkg::mulq(34'(nrm[k]), 34'(sin_q)));
      cc1 <= 34'(aavr_pkg::ONE_Q30) - 34'(cos_q);
      c1 <= 34'(cos_q);

      for (int k = 0; k < 6; k++) tt[k] <= 34'(aavr_pkg::mulq(pp[k], cc1));
      qs2 <= qs1;
      c2 <= c1;

      mm[0] <= c2 + tt[0];
      mm[1] <= tt[1] - qs2[2];
      mm[2] <= tt[2] + qs2[1];
      mm[3] <= tt[1] + qs2[2];
      mm[4] <= c2 + tt[3];
      mm[5] <= tt[4] - qs2[0];
      mm[6] <= tt[2] - qs2[1];
      mm[7] <= tt[4] + qs2[0];
      mm[8] <= c2 + tt[5];
    end
  end

  // Each coordinate is split at bit 24 so every product stays narrow.
  always_comb begin
    for (int j = 0; j < 3; j++) vx[j] = (W + 24)'($signed(sd[NL+3].vec[j]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          ph[r][j] <= $signed(HW'(vx[j] >>> 24)) * mm[3*r+j];
          pl[r][j] <= $signed({1'b0, vx[j][23:0]}) * mm[3*r+j];
        end
      end
      for (int r = 0; r < 3; r++) begin
        hs[r] <= (PHW + 2)'(ph[r][0]) + (PHW + 2)'(ph[r][1]) + (PHW + 2)'(ph[r][2]);
        ls[r] <= 61'(pl[r][0]) + 61'(pl[r][1]) + 61'(pl[r][2]) + 61'(aavr_pkg::HALF_Q30);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tot[r] = (SW'(hs[r]) <<< 24) + SW'(ls[r]);
      yv[r] = (SW - 30)'(tot[r] >>> 30);
      if (yv[r] > (SW - 30)'(MAXV)) sat_c[r] = MAXV;
      else if (yv[r] < (SW - 30)'(MINV)) sat_c[r] = MINV;
      else sat_c[r] = yv[r][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sd[SL].zang) begin
        for (int r = 0; r < 3; r++) rot[r] <= sd[SL].vec[r];
        status <= aavr_pkg::STATUS_OK;
      end else if (sd[SL].zax) begin
        for (int r = 0; r < 3; r++) rot[r] <= '0;
        status <= aavr_pkg::STATUS_ZERO_AXIS;
      end else begin
        rot <= sat_c;
        status <= aavr_pkg::STATUS_OK;
      end
    end
  end

  assign result.valid = vld[TOT];
  assign result.rot_x = rot[0];
  assign result.rot_y = rot[1];
  assign result.rot_z = rot[2];
  assign result.status = status;

endmodule

/* rtl/core/aavr_checker.sv */
`include "axis_angle_vector_rotate_core_defines.svh"

module aavr_checker #(
  parameter int COORD_WIDTH = aavr_pkg::COORD_WIDTH
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [COORD_WIDTH-1:0] rot_x,
  input logic [COORD_WIDTH-1:0] rot_y,
  input logic [COORD_WIDTH-1:0] rot_z,
  input logic status
);

  // Input is taken exactly when the output slot is free or being drained.
  `AAVR_ASSERT(a_ready_follows_output, in_ready == (!out_valid || out_ready), "input ready does not track output slot")

  `AAVR_ASSERT(a_error_zeroes, (out_valid && status) |-> (rot_x == '0 && rot_y == '0 && rot_z == '0), "error word carries a nonzero vector")

  `AAVR_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(rot_x) && $stable(status)), "stalled result word changed")

  `AAVR_ASSERT(a_in_valid_known, !$isunknown(in_valid), "input valid is unknown")

  `AAVR_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid, "result valid after reset")

endmodule

bind axis_angle_vector_rotate_core aavr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_aavr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (item.valid),
  .in_ready (item.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .rot_x    (result.rot_x),
  .rot_y    (result.rot_y),
  .rot_z    (result.rot_z),
  .status   (result.status)
);

/* verif/aavr_rotate_checker.sv */
`timescale 1ns / 100ps

module aavr_rotate_checker (
  input logic clk,
  input logic rst,
  aavr_item_if item,
  aavr_result_if result,
  output int fail_count,
  output int pending,
  output int zero_axis_seen,
  output int sat_seen
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic status;
  } rotated_t;

  rotated_t rotated_q[$];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + aavr_pkg::HALF_Q30) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Exact row product rounded to Q16.16, with the vector split at bit 24.
  function automatic longint row_dot(longint v[3], longint m0, longint m1, longint m2);
    longint mm[3];
    longint h, l, vh, vl, r, hi, lo;
    mm[0] = m0; mm[1] = m1; mm[2] = m2;
    h = 0;
    l = 0;
    for (int j = 0; j < 3; j++) begin
      vh = v[j] >>> 24;
      vl = v[j] - vh * (64'sd1 <<< 24);
      h += vh * mm[j];
      l += vl * mm[j];
    end
    l += aavr_pkg::HALF_Q30;
    r = (h + (l >>> 24)) >>> 6;
    hi = 64'sd2147483647;
    lo = -hi - 1;
    return r > hi ? hi : (r < lo ? lo : r);
  endfunction

  function automatic rotated_t rotate_vector(logic signed [31:0] vx, vy, vz, ax, ay, az, ang);
    rotated_t o;
    longint v[3], a[3], n[3], m[9];
    longint unsigned um[3], mx, sum, nm;
    longint angl, r, rem, x, y, c, s, cc, dx, dy;
    int len, q;
    v[0] = vx; v[1] = vy; v[2] = vz;
    a[0] = ax; a[1] = ay; a[2] = az;
    angl = ang;
    o.status = aavr_pkg::STATUS_OK;
    if (angl == 0) begin
      o.x = vx; o.y = vy; o.z = vz;
      return o;
    end
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      um[k] = a[k] < 0 ? longint'(-a[k]) : longint'(a[k]);
      if (um[k] > mx) mx = um[k];
    end
    if (mx == 0) begin
      o.x = 0; o.y = 0; o.z = 0;
      o.status = aavr_pkg::STATUS_ZERO_AXIS;
      return o;
    end
    len = 0;
    while (len < 64 && (mx >> len) != 0) len++;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      if (len > 30) um[k] = um[k] >> (len - 30);
      else um[k] = um[k] << (30 - len);
      sum += um[k] * um[k];
    end
    sum = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      nm = (um[k] << 30) / sum;
      n[k] = a[k] < 0 ? -longint'(nm) : longint'(nm);
    end
    r = angl % aavr_pkg::DEG_FULL;
    if (r < 0) r += aavr_pkg::DEG_FULL;
    q = int'(r / aavr_pkg::DEG_QUARTER);
    rem = r - longint'(q) * aavr_pkg::DEG_QUARTER;
    x = aavr_pkg::CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < aavr_pkg::CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (rem >= 0) begin
        x -= dx; y += dy; rem -= aavr_pkg::ATAN_DEG_Q16[i];
      end else begin
        x += dx; y -= dy; rem += aavr_pkg::ATAN_DEG_Q16[i];
      end
    end
    case (q & 3)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    cc = aavr_pkg::ONE_Q30 - c;
    m[0] = c + q30_mul(q30_mul(n[0], n[0]), cc);
    m[1] = q30_mul(q30_mul(n[0], n[1]), cc) - q30_mul(n[2], s);
    m[2] = q30_mul(q30_mul(n[0], n[2]), cc) + q30_mul(n[1], s);
    m[3] = q30_mul(q30_mul(n[1], n[0]), cc) + q30_mul(n[2], s);
    m[4] = c + q30_mul(q30_mul(n[1], n[1]), cc);
    m[5] = q30_mul(q30_mul(n[1], n[2]), cc) - q30_mul(n[0], s);
    m[6] = q30_mul(q30_mul(n[2], n[0]), cc) - q30_mul(n[1], s);
    m[7] = q30_mul(q30_mul(n[2], n[1]), cc) + q30_mul(n[0], s);
    m[8] = c + q30_mul(q30_mul(n[2], n[2]), cc);
    o.x = 32'(row_dot(v, m[0], m[1], m[2]));
    o.y = 32'(row_dot(v, m[3], m[4], m[5]));
    o.z = 32'(row_dot(v, m[6], m[7], m[8]));
    return o;
  endfunction

  assign pending = rotated_q.size();

  initial begin
    fail_count = 0;
    zero_axis_seen = 0;
    sat_seen = 0;
  end

  always @(posedge clk) begin
    rotated_t want;
    if (!rst && item.valid && item.ready) begin
      rotated_q = {rotated_q, rotate_vector(item.vec_x, item.vec_y, item.vec_z,
                                            item.axis_x, item.axis_y, item.axis_z,
                                            item.angle_deg)};
    end
    if (!rst && result.valid && result.ready) begin
      if (rotated_q.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = rotated_q.pop_front();
        if (want.status == aavr_pkg::STATUS_ZERO_AXIS) zero_axis_seen++;
        if (want.x == 32'sh7fffffff || want.x == 32'sh80000000) sat_seen++;
        if (result.rot_x !== want.x) begin
          $error("rot_x: expected %0d, actual %0d", want.x, result.rot_x);
          fail_count++;
        end
        if (result.rot_y !== want.y) begin
          $error("rot_y: expected %0d, actual %0d", want.y, result.rot_y);
          fail_count++;
        end
        if (result.rot_z !== want.z) begin
          $error("rot_z: expected %0d, actual %0d", want.z, result.rot_z);
          fail_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result.status);
          fail_count++;
        end
      end
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int RAND_WORDS = 430;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count, pending, zero_axis_seen, sat_seen;
  int send_idle_pct, recv_idle_pct;
  int cycles = 0;
  int stall_left = 0;
  int words_sent = 0;
  logic stall_req = 1'b0;
  logic stall_done = 1'b0;

  aavr_item_if item ();
  aavr_result_if result ();

  axis_angle_vector_rotate_core u_top (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result)
  );

  aavr_rotate_checker u_checker (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result),
    .fail_count(fail_count),
    .pending(pending),
    .zero_axis_seen(zero_axis_seen),
    .sat_seen(sat_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver; one long hold-off is counted here so the pipeline fills.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result.ready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_left <= LONG_STALL;
      stall_done <= 1'b1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(logic [31:0] vx, vy, vz, ax, ay, az, ang);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid <= 1'b1;
    item.vec_x <= vx;
    item.vec_y <= vy;
    item.vec_z <= vz;
    item.axis_x <= ax;
    item.axis_y <= ay;
    item.axis_z <= az;
    item.angle_deg <= ang;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                        : 32'h80000000 + $urandom_range(3);
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(5))
      0: return 32'($signed($urandom_range(8)) - 4) * 32'(90 * 65536);
      1: return 32'($signed($urandom_range(720)) - 360) <<< 16;
      2: return 32'($signed($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] ax, ay, az;
    ax = rand_coord();
    ay = rand_coord();
    az = rand_coord();
    case ($urandom_range(19))
      0: begin ax = 0; ay = 0; az = 0; end
      1: begin ay = 0; az = 0; end
      2: begin ax = $urandom_range(7); ay = $urandom_range(7); az = 0; end
      default: ;
    endcase
    send_word(rand_coord(), rand_coord(), rand_coord(), ax, ay, az,
              $urandom_range(24) == 0 ? 32'd0 : rand_angle());
  endtask

  initial begin
    item.valid = 1'b0;
    item.vec_x = '0;
    item.vec_y = '0;
    item.vec_z = '0;
    item.axis_x = '0;
    item.axis_y = '0;
    item.axis_z = '0;
    item.angle_deg = '0;
    result.ready = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 62;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero angle passes the vector, even for a zero axis.
    send_word(32'h7fffffff, 32'h80000000, 32'h12345678, 0, 0, 0, 0);
    send_word(32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000, 0, 0, 0);
    // Zero axis with nonzero angle reports the error status.
    send_word(32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0, 32'h005a0000);
    send_word(32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0, 32'h80000000);
    // Quarter turns in every quadrant, and a full turn that is not a zero angle.
    send_word(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'h005a0000);
    send_word(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'h00b40000);
    send_word(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'h010e0000);
    send_word(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'h01680000);
    send_word(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'hffa60000);
    send_word(32'h00010000, 32'h00020000, 0, 32'h00010000, 32'h00010000, 32'h00010000, 1);
    // Extreme axis lengths: largest magnitude, smallest nonzero, mixed signs.
    send_word(32'h00010000, 32'h00010000, 0, 32'h80000000, 0, 0, 32'h002d0000);
    send_word(32'h00010000, 32'h00010000, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h7fffffff);
    send_word(32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 1, 32'h001e0000);
    send_word(32'h00010000, 32'h00010000, 32'h00010000, 32'hffffffff, 1, 0, 32'h80000001);
    // Extreme vectors that saturate after rotation.
    send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 32'h00010000, 32'h002d0000);
    send_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h00010000, 32'h00010000, 0,
              32'h00b40000);
    send_word(32'h80000000, 32'h7fffffff, 0, 32'h00010000, 0, 0, 32'h00b40000);

    // Let every result drain before the random part starts.
    item.valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);

    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == 20) stall_req <= 1'b1;
      if (i == 150) begin
        send_idle_pct = 62;
        recv_idle_pct = 23;
      end
      if (i == 290) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random();
    end
    item.valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d words with random idling and one long output stall;", words_sent);
    $display("%0d zero-axis errors and %0d saturated x results were checked.",
             zero_axis_seen, sat_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/aavr_pkg.sv
rtl/core/aavr_if.sv
rtl/core/aavr_axis_norm.sv
rtl/core/aavr_sincos.sv
rtl/core/axis_angle_vector_rotate_core.sv
rtl/core/aavr_checker.sv
verif/aavr_rotate_checker.sv
verif/testbench.sv
